[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held
`define SRNH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sticky next-hop check failed");

// Clocked assertion that also holds across reset
`define SRNH_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sticky next-hop check failed");

`endif

[hw/rtl/srnh_pkg.sv]
// ----------------------------------------------------------------------------
// srnh_pkg
// Request types and codes of the sticky random next-hop selector.
// ----------------------------------------------------------------------------
`default_nettype none
package srnh_pkg;

    // Request kinds
    localparam logic [1:0] KIND_LOOKUP   = 2'd0;
    localparam logic [1:0] KIND_ADD      = 2'd1;
    localparam logic [1:0] KIND_REMOVE   = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // Galois feedback mask, x^32+x^22+x^2+x+1
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] face_id;
        logic [15:0] ingress_face;
        logic        has_name;
        logic [31:0] segment_key;
    } t_in_req;

    typedef struct packed {
        logic        has_egress;
        logic [15:0] egress_face;
        logic        reused;
        logic [4:0]  hop_count;
    } t_out_req;

endpackage
`default_nettype wire

[hw/rtl/sticky_random_next_hop_select_top.sv]
// ----------------------------------------------------------------------------
// sticky_random_next_hop_select_top
// Ordered next-hop set in a one-port-read memory with sticky random lookup.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                | payload
//  in        | input     | i_in_valid / o_in_stall  | srnh_pkg::t_in_req
//  out       | output    | o_out_valid / i_out_stall| srnh_pkg::t_out_req
//  cfg       | input     | i_cfg_valid / o_cfg_ready| lfsr seed, 32 bit
//
// One request at a time; the input stalls from acceptance until the result is
// loaded. Every request ends in the output stage, which waits while the out side
// stalls. Add, reused lookup, unused kind: one scan. Remove: scan, then a
// compaction pass if the face is found. Lookup with a draw: scan, bit-serial
// modulo of the 32-bit draw, then a pick scan that stops at the chosen entry.
// Synchronous active-low reset empties the set; no clearing pass is needed.
// A result waits in the output register while the out side stalls.
`default_nettype none
module sticky_random_next_hop_select_top #(
    parameter int MAX_NEXT_HOPS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire srnh_pkg::t_in_req   i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output srnh_pkg::t_out_req       o_out_data,
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [31:0]              i_cfg_data
);

    localparam int AW = $clog2(MAX_NEXT_HOPS);
    localparam int CW = $clog2(MAX_NEXT_HOPS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_MOD, S_PICK, S_OUT
    } t_state;

    t_state             r_state;
    srnh_pkg::t_in_req  r_req;
    logic [CW-1:0]      r_total;
    logic [31:0]        r_key;
    logic               r_key_vld;
    logic [15:0]        r_last;
    logic [31:0]        r_lfsr;

    // scan pipeline
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_dpos;
    logic               r_dv;
    logic [15:0]        r_rd_data;
    logic               r_f_fnd;
    logic [CW-1:0]      r_f_pos;
    logic               r_i_fnd;
    logic               r_l_fnd;

    // modulo unit
    logic [31:0]        r_quo;
    logic [CW-1:0]      r_rem;
    logic [CW-1:0]      r_div;
    logic [4:0]         r_bit;
    logic [CW-1:0]      r_seen;

    // result
    logic               r_has;
    logic [15:0]        r_egr;
    logic               r_reu;
    logic               r_ovld;
    srnh_pkg::t_out_req r_out;

    logic [15:0]        mem [MAX_NEXT_HOPS];

    logic               in_acc;
    logic               out_free;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      wa;
    logic [15:0]        wd;
    logic [CW-1:0]      prev_pos;
    logic [31:0]        n_lfsr;
    logic [CW-1:0]      elig;
    logic [CW:0]        rem_sh;
    logic [CW+4:0]      cnt_ext;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign out_free    = !r_ovld || !i_out_stall;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;
    assign rd_addr     = r_cnt[AW-1:0];
    assign prev_pos    = r_dpos - CW'(1);
    assign n_lfsr      = r_lfsr[0] ? ((r_lfsr >> 1) ^ srnh_pkg::LFSR_MASK) : (r_lfsr >> 1);
    assign elig        = (r_total - CW'(r_i_fnd) == '0) ? CW'(1) : r_total - CW'(r_i_fnd);
    assign rem_sh      = {r_rem, r_quo[31]};
    assign cnt_ext     = (CW + 5)'(r_total);

    // memory write port: append on add, compaction on remove
    always_comb begin
        we = 1'b0;
        wa = r_total[AW-1:0];
        wd = r_req.face_id;
        if (r_state == S_SCAN && !(r_cnt < r_total) && !r_dv
                && r_req.kind == srnh_pkg::KIND_ADD && !r_f_fnd
                && r_total < CW'(MAX_NEXT_HOPS)) begin
            we = 1'b1;
        end else if (r_state == S_SHIFT && r_dv) begin
            we = 1'b1;
            wa = prev_pos[AW-1:0];
            wd = r_rd_data;
        end
    end

    // hop list memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_data <= mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_key     <= '0;
            r_key_vld <= 1'b0;
            r_last    <= '0;
            r_lfsr    <= 32'd1;
            r_ovld    <= 1'b0;
            r_dv      <= 1'b0;
            r_cnt     <= '0;
        end else begin
            // output stage reloads the register itself
            if (r_ovld && !i_out_stall && r_state != S_OUT) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_lfsr <= (i_cfg_data == '0) ? 32'd1 : i_cfg_data;
                    end
                    if (in_acc) begin
                        r_req   <= i_in_data;
                        r_cnt   <= '0;
                        r_dv    <= 1'b0;
                        r_f_fnd <= 1'b0;
                        r_f_pos <= '0;
                        r_i_fnd <= 1'b0;
                        r_l_fnd <= 1'b0;
                        r_has   <= 1'b0;
                        r_egr   <= '0;
                        r_reu   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_dv   <= (r_cnt < r_total);
                    r_dpos <= r_cnt;
                    if (r_cnt < r_total) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (r_dv) begin
                        if (r_rd_data == r_req.face_id && !r_f_fnd) begin
                            r_f_fnd <= 1'b1;
                            r_f_pos <= r_dpos;
                        end
                        if (r_rd_data == r_req.ingress_face) r_i_fnd <= 1'b1;
                        if (r_rd_data == r_last) r_l_fnd <= 1'b1;
                    end
                    if (!(r_cnt < r_total) && !r_dv) begin
                        r_state <= S_OUT;
                        case (r_req.kind)
                            srnh_pkg::KIND_ADD: begin
                                if (we) r_total <= r_total + CW'(1);
                            end
                            srnh_pkg::KIND_REMOVE: begin
                                if (r_f_fnd) begin
                                    r_cnt   <= r_f_pos + CW'(1);
                                    r_state <= S_SHIFT;
                                end
                            end
                            srnh_pkg::KIND_LOOKUP: begin
                                if (r_total != '0 && !(r_total == CW'(1) && r_i_fnd)) begin
                                    if (r_req.has_name && r_key_vld && r_key == r_req.segment_key
                                            && r_l_fnd) begin
                                        r_has <= 1'b1;
                                        r_reu <= 1'b1;
                                        r_egr <= r_last;
                                    end else begin
                                        if (r_req.has_name) begin
                                            r_key     <= r_req.segment_key;
                                            r_key_vld <= 1'b1;
                                        end
                                        r_lfsr  <= n_lfsr;
                                        r_quo   <= n_lfsr;
                                        r_rem   <= '0;
                                        r_div   <= elig;
                                        r_bit   <= '0;
                                        r_state <= S_MOD;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SHIFT: begin
                    r_dv   <= (r_cnt < r_total);
                    r_dpos <= r_cnt;
                    if (r_cnt < r_total) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (!(r_cnt < r_total) && !r_dv) begin
                        r_total <= r_total - CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_MOD: begin
                    // restoring modulo, one dividend bit per cycle
                    r_quo <= {r_quo[30:0], 1'b0};
                    if (rem_sh >= {1'b0, r_div}) begin
                        r_rem <= rem_sh[CW-1:0] - r_div;
                    end else begin
                        r_rem <= rem_sh[CW-1:0];
                    end
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd31) begin
                        r_cnt   <= '0;
                        r_dv    <= 1'b0;
                        r_seen  <= '0;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_dv   <= (r_cnt < r_total);
                    r_dpos <= r_cnt;
                    if (r_cnt < r_total) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (r_dv && r_rd_data != r_req.ingress_face) begin
                        if (r_seen == r_rem) begin
                            r_has   <= 1'b1;
                            r_egr   <= r_rd_data;
                            r_last  <= r_rd_data;
                            r_state <= S_OUT;
                        end else begin
                            r_seen <= r_seen + CW'(1);
                        end
                    end else if (!(r_cnt < r_total) && !r_dv) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovld            <= 1'b1;
                        r_out.has_egress  <= r_has;
                        r_out.egress_face <= r_egr;
                        r_out.reused      <= r_reu;
                        r_out.hop_count   <= cnt_ext[4:0];
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/srnh_checker.sv]
// ----------------------------------------------------------------------------
// srnh_checker
// Port-level checks of the sticky random next-hop selector.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module srnh_checker #(
    parameter int MAX_NEXT_HOPS = 16
) (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      i_in_valid,
    input wire                      o_in_stall,
    input wire                      o_out_valid,
    input wire                      i_out_stall,
    input wire srnh_pkg::t_out_req  o_out_data
);

    // a stalled result holds
    `SRNH_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
    // one request at a time
    `SRNH_ASSERT(a_busy, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)
    // set size bounded
    `SRNH_ASSERT(a_count, i_clk, i_rst_n, o_out_valid |-> (32'(o_out_data.hop_count) <= 32'(MAX_NEXT_HOPS)))
    // reuse implies an egress, no egress implies zero face
    `SRNH_ASSERT(a_reuse, i_clk, i_rst_n, o_out_valid |-> ((!o_out_data.reused || o_out_data.has_egress) && (o_out_data.has_egress || o_out_data.egress_face == 16'd0)))
    // reset leaves no result pending
    `SRNH_ASSERT_NR(a_rst, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind sticky_random_next_hop_select_top srnh_checker #(
    .MAX_NEXT_HOPS(MAX_NEXT_HOPS)
) u_srnh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

[bench/tb_sticky_random_next_hop_select_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sticky_random_next_hop_select_top
// Self-checking bench for the sticky random next-hop selector. Requests come
// from a queue filled by the stimulus process; a clocked driver presents them
// with random gaps. A clocked monitor checks each result against a predictor
// of the next-hop set, the sticky key, and the LFSR.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_sticky_random_next_hop_select_top;

    localparam int HOPS_MAX   = 16;
    localparam int WDOG_LIMIT = 20000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    srnh_pkg::t_in_req   in_data;
    logic                out_valid;
    logic                out_stall;
    srnh_pkg::t_out_req  out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [31:0]         cfg_data;

    sticky_random_next_hop_select_top #(.MAX_NEXT_HOPS(HOPS_MAX)) u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    // Clock, 2 ns period
    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state
    logic [15:0] hop_set [HOPS_MAX];
    int          hop_num;
    logic [31:0] key_held;
    logic        key_seen;
    logic [15:0] sticky_face;
    logic [31:0] lfsr_val;

    srnh_pkg::t_in_req  pending_reqs [$];
    srnh_pkg::t_out_req expected_results [$];
    int  errors;
    bit  quiet;        // no idling in the final part
    bit  rx_hold;      // long receiver hold-off request
    bit  cfg_req;
    logic [31:0] cfg_word;
    bit  cfg_done;
    int  idle_cnt;

    // Stall and ready as sampled at the last rising edge
    logic in_stall_q;
    logic cfg_ready_q;
    always @(posedge clk) in_stall_q <= in_stall;
    always @(posedge clk) cfg_ready_q <= cfg_ready;

    function automatic int find_face(logic [15:0] f);
        for (int i = 0; i < hop_num; i++)
            if (hop_set[i] == f) return i;
        return -1;
    endfunction

    function automatic void load_seed(logic [31:0] s);
        lfsr_val = (s == 32'd0) ? 32'd1 : s;
    endfunction

    // Compute the result of one request and update the predictor
    function automatic srnh_pkg::t_out_req predict_hop_select(srnh_pkg::t_in_req r);
        srnh_pkg::t_out_req res;
        int pos, elig, pick, seen;
        bit ing_in, draw;
        res = '0;
        if (r.kind == srnh_pkg::KIND_ADD) begin
            if (find_face(r.face_id) < 0 && hop_num < HOPS_MAX) begin
                hop_set[hop_num] = r.face_id;
                hop_num++;
            end
        end else if (r.kind == srnh_pkg::KIND_REMOVE) begin
            pos = find_face(r.face_id);
            if (pos >= 0) begin
                for (int i = pos; i + 1 < hop_num; i++) hop_set[i] = hop_set[i + 1];
                hop_num--;
            end
        end else if (r.kind == srnh_pkg::KIND_LOOKUP) begin
            ing_in = find_face(r.ingress_face) >= 0;
            if (hop_num != 0 && !(hop_num == 1 && ing_in)) begin
                draw = 1'b1;
                if (r.has_name) begin
                    if (!key_seen || key_held != r.segment_key) begin
                        key_held = r.segment_key;
                        key_seen = 1'b1;
                    end else if (find_face(sticky_face) >= 0) begin
                        draw = 1'b0;
                        res.has_egress  = 1'b1;
                        res.egress_face = sticky_face;
                        res.reused      = 1'b1;
                    end
                end
                if (draw) begin
                    elig = hop_num - (ing_in ? 1 : 0);
                    if (elig == 0) elig = 1;
                    lfsr_val = lfsr_val[0] ? ((lfsr_val >> 1) ^ srnh_pkg::LFSR_MASK)
                                           : (lfsr_val >> 1);
                    pick = int'(lfsr_val % 32'(elig));
                    seen = 0;
                    for (int i = 0; i < hop_num; i++) begin
                        if (hop_set[i] != r.ingress_face) begin
                            if (seen == pick) begin
                                res.has_egress  = 1'b1;
                                res.egress_face = hop_set[i];
                                sticky_face     = hop_set[i];
                                break;
                            end
                            seen++;
                        end
                    end
                end
            end
        end
        res.hop_count = 5'(hop_num);
        return res;
    endfunction

    // Driver: requests change on the falling edge
    int  tx_gap;
    bit  tx_pause;
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall_q) begin
                void'(pending_reqs.pop_front());
            end
            if (in_valid && in_stall_q) begin
                // hold the stalled request
            end else if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 && !tx_pause) begin
                if (!quiet && $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_data  <= pending_reqs[0];
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall with random bursts and an optional long hold-off
    int rx_gap;
    int hold_left;
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (rx_hold) begin
            rx_hold   = 1'b0;
            hold_left = 300;
            out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Configuration writes
    always @(negedge clk) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
        end else if (cfg_valid && cfg_ready_q) begin
            cfg_valid <= 1'b0;
            cfg_done  = 1'b1;
        end else if (cfg_req && !cfg_valid) begin
            cfg_req   = 1'b0;
            cfg_valid <= 1'b1;
            cfg_data  <= cfg_word;
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge clk) begin
        srnh_pkg::t_out_req exp_r;
        bit act;
        if (rst_n) begin
            act = 1'b0;
            if (in_valid && !in_stall) begin
                expected_results.push_back(predict_hop_select(in_data));
                act = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                load_seed(cfg_data);
                act = 1'b1;
            end
            if (out_valid && !out_stall) begin
                act = 1'b1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, out_data);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== out_data) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, exp_r, out_data);
                        errors++;
                    end
                end
            end
            idle_cnt <= act ? 0 : idle_cnt + 1;
            if (idle_cnt >= WDOG_LIMIT) begin
                $display("tb_sticky_random_next_hop_select_top failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_seed(logic [31:0] s);
        cfg_done = 1'b0;
        cfg_word = s;
        cfg_req  = 1'b1;
        while (!cfg_done) @(posedge clk);
    endtask

    function automatic srnh_pkg::t_in_req make_req(logic [1:0] k, logic [15:0] f,
                                                   logic [15:0] g, logic n,
                                                   logic [31:0] key);
        srnh_pkg::t_in_req r;
        r.kind = k; r.face_id = f; r.ingress_face = g;
        r.has_name = n; r.segment_key = key;
        return r;
    endfunction

    // Random request biased towards a small face pool so that hits are common
    function automatic srnh_pkg::t_in_req rand_req(int face_pool);
        logic [15:0] f, g;
        int sel;
        f = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, face_pool));
        g = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, face_pool));
        sel = $urandom_range(0, 99);
        return make_req(sel < 50 ? srnh_pkg::KIND_LOOKUP : sel < 78 ? srnh_pkg::KIND_ADD :
                        sel < 98 ? srnh_pkg::KIND_REMOVE : srnh_pkg::KIND_RESERVED,
                        f, g, 1'($urandom),
                        ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 3)));
    endfunction

    logic [31:0] seeds [4] = '{32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678};

    initial begin
        errors = 0; quiet = 0; rx_hold = 0; cfg_req = 0; cfg_done = 0;
        tx_gap = 0; rx_gap = 0; hold_left = 0; tx_pause = 0; idle_cnt = 0;
        in_valid = 0; in_data = '0; out_stall = 0; cfg_valid = 0; cfg_data = '0;
        hop_num = 0; key_held = '0; key_seen = 0; sticky_face = '0;
        load_seed(32'd1);
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: empty set, lone ingress, fill, duplicates, full set, removes
        pending_reqs.push_back(make_req(srnh_pkg::KIND_LOOKUP, 16'd0, 16'd0, 1'b1,
                                        32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(srnh_pkg::KIND_REMOVE, 16'hFFFF, 16'd0, 1'b0, 32'd0));
        pending_reqs.push_back(make_req(srnh_pkg::KIND_ADD, 16'hFFFF, 16'd0, 1'b0, 32'd0));
        pending_reqs.push_back(make_req(srnh_pkg::KIND_LOOKUP, 16'd0, 16'hFFFF, 1'b1, 32'd0));
        pending_reqs.push_back(make_req(srnh_pkg::KIND_ADD, 16'hFFFF, 16'd0, 1'b0, 32'd0));
        for (int i = 0; i < 16; i++)
            pending_reqs.push_back(make_req(srnh_pkg::KIND_ADD, 16'(i), 16'd0, 1'b0, 32'd0));
        pending_reqs.push_back(make_req(srnh_pkg::KIND_LOOKUP, 16'd0, 16'd3, 1'b1, 32'd0));
        pending_reqs.push_back(make_req(srnh_pkg::KIND_LOOKUP, 16'd0, 16'd3, 1'b1, 32'd0));
        pending_reqs.push_back(make_req(srnh_pkg::KIND_LOOKUP, 16'd0, 16'd3, 1'b0, 32'd0));
        pending_reqs.push_back(make_req(srnh_pkg::KIND_REMOVE, 16'hFFFF, 16'd0, 1'b0, 32'd0));
        pending_reqs.push_back(make_req(srnh_pkg::KIND_RESERVED, 16'hFFFF, 16'hFFFF, 1'b1,
                                        32'hFFFF_FFFF));
        wait_drained();

        // Random phases, one per seed; sticky face removal arises naturally
        for (int ph = 0; ph < 4; ph++) begin
            write_seed(seeds[ph]);
            for (int i = 0; i < 180; i++) pending_reqs.push_back(rand_req(ph < 2 ? 20 : 5));
            if (ph == 1) begin
                rx_hold = 1'b1;
            end
            if (ph == 2) begin
                // sender pause until all results have come
                tx_pause = 1'b0;
                while (pending_reqs.size() > 90) @(posedge clk);
                tx_pause = 1'b1;
                while (expected_results.size() != 0) @(posedge clk);
                tx_pause = 1'b0;
            end
            if (ph == 3) quiet = 1'b1;
            while (ph == 2 && pending_reqs.size() > 100) @(posedge clk);
            wait_drained();
        end

        if (errors == 0) begin
            $display("tb_sticky_random_next_hop_select_top passed");
        end else begin
            $display("tb_sticky_random_next_hop_select_top failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
